// File: rtl/core/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg
// shared types and constants of the separable 5x5 blur
// ----------------------------------------------------------------------------
`default_nettype none

package sbl_pkg;

   localparam int LINE_ROWS  = 4;
   localparam int BANK_W     = 2;
   localparam int COL_W      = 11;
   localparam int HGT_W      = 16;
   localparam int ROW_W      = 17;
   localparam int POS_W      = 27;
   localparam int CNT_W      = 5;
   localparam int SUM_W      = 12;
   localparam int VSUM_W     = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [COL_W-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [HGT_W-1:0] RESET_HEIGHT = 16'd480;

   typedef enum logic [1:0] {
      ST_SETUP,
      ST_LOAD,
      ST_DIVIDE,
      ST_RUN
   } sbl_state_type;

   typedef struct packed {
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
      logic       flush;
   } sbl_req_type;

   typedef struct packed {
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic       frame_end;
   } sbl_rsp_type;

   // per-item control handed from the position tracker to the lanes
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [BANK_W-1:0] bank;
      logic              fresh_ok;
      logic              out_ok;
      logic              frame_end;
      logic              edge_l2;
      logic              edge_l1;
      logic              edge_r1;
      logic              edge_r2;
      logic              top2;
      logic              top1;
      logic              bot1;
      logic              bot2;
   } sbl_item_type;

endpackage

`default_nettype wire

// File: rtl/core/sbl_ram.sv
// ----------------------------------------------------------------------------
// sbl_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/core/sbl_ctrl.sv
// ----------------------------------------------------------------------------
// sbl_ctrl
// configuration registers, frame position tracking and restart divider
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_ctrl #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [sbl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [sbl_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire logic                                take,
   output logic                                     run,
   output logic                                     pix_slot,
   output sbl_pkg::sbl_item_type                    item
);

   localparam int PW = sbl_pkg::POS_W;
   localparam int CW = sbl_pkg::COL_W;
   localparam int HW = sbl_pkg::HGT_W;
   localparam int RW = sbl_pkg::ROW_W;
   localparam int NW = sbl_pkg::CNT_W;

   sbl_pkg::sbl_state_type state_ff, state_in;
   logic [CW-1:0] fwidth_ff, fwidth_in;
   logic [HW-1:0] fheight_ff, fheight_in;
   logic [CW-1:0] wid_ff, wid_in;
   logic [HW-1:0] hgt_ff, hgt_in;
   logic [PW-1:0] npix_ff, npix_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [CW-1:0] qcol_ff, qcol_in;
   logic [RW-1:0] qrow_ff, qrow_in;
   logic [PW-1:0] dvd_ff, dvd_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [NW-1:0] cnt_ff, cnt_in;

   logic [CW-1:0] wuse;
   logic [HW-1:0] huse;
   logic [PW:0]   total;
   logic [PW:0]   pos_inc;
   logic [PW-1:0] pos_wrap;
   logic [CW:0]   rem_shift;
   logic          rem_ge;
   logic [CW-1:0] rem_step;
   logic [PW-1:0] dvd_step;
   logic [RW-1:0] hgt_ext;

   always_comb begin
      if (fwidth_ff < 11'd5) begin
         wuse = 11'd5;
      end else if (32'(fwidth_ff) > MAX_WIDTH) begin
         wuse = CW'(MAX_WIDTH);
      end else begin
         wuse = fwidth_ff;
      end
   end

   assign huse      = (fheight_ff == '0) ? HW'(1) : fheight_ff;
   assign total     = (PW+1)'(npix_ff) + {16'd0, wid_ff, 1'b0} + (PW+1)'(2);
   assign pos_inc   = {1'b0, pos_ff} + (PW+1)'(1);
   assign pos_wrap  = ({1'b0, pos_ff} >= total) ? '0 : pos_ff;
   assign hgt_ext   = {1'b0, hgt_ff};

   // one restoring step: remainder against the used width
   assign rem_shift = {rem_ff, dvd_ff[PW-1]};
   assign rem_ge    = rem_shift >= {1'b0, wid_ff};
   assign rem_step  = rem_ge ? CW'(rem_shift - {1'b0, wid_ff}) : rem_shift[CW-1:0];
   assign dvd_step  = {dvd_ff[PW-2:0], rem_ge};

   always_comb begin
      state_in   = state_ff;
      fwidth_in  = fwidth_ff;
      fheight_in = fheight_ff;
      wid_in     = wid_ff;
      hgt_in     = hgt_ff;
      npix_in    = npix_ff;
      pos_in     = pos_ff;
      qcol_in    = qcol_ff;
      qrow_in    = qrow_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      unique case (state_ff)
         sbl_pkg::ST_SETUP: begin
            wid_in   = wuse;
            hgt_in   = huse;
            npix_in  = PW'(wuse) * PW'(huse);
            state_in = sbl_pkg::ST_LOAD;
         end
         sbl_pkg::ST_LOAD: begin
            pos_in   = pos_wrap;
            dvd_in   = (pos_wrap > PW'(1)) ? PW'(pos_wrap - PW'(2)) : '0;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = sbl_pkg::ST_DIVIDE;
         end
         sbl_pkg::ST_DIVIDE: begin
            rem_in = rem_step;
            dvd_in = dvd_step;
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff == NW'(PW - 1)) begin
               qcol_in  = rem_step;
               qrow_in  = dvd_step[RW-1:0];
               state_in = sbl_pkg::ST_RUN;
            end
         end
         sbl_pkg::ST_RUN: begin
            if (take) begin
               pos_in = (pos_inc >= total) ? '0 : pos_inc[PW-1:0];
               if (pos_ff < PW'(2)) begin
                  qcol_in = '0;
                  qrow_in = '0;
               end else if (qcol_ff == wid_ff - CW'(1)) begin
                  qcol_in = '0;
                  qrow_in = qrow_ff + RW'(1);
               end else begin
                  qcol_in = qcol_ff + CW'(1);
               end
            end
         end
         default: state_in = sbl_pkg::ST_SETUP;
      endcase
      if (csr_we) begin
         state_in = sbl_pkg::ST_SETUP;
         unique case (csr_index)
            sbl_pkg::CSR_FRAME_WIDTH:  fwidth_in  = csr_data[CW-1:0];
            sbl_pkg::CSR_FRAME_HEIGHT: fheight_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sbl_pkg::ST_SETUP;
         fwidth_ff  <= sbl_pkg::RESET_WIDTH;
         fheight_ff <= sbl_pkg::RESET_HEIGHT;
         pos_ff     <= '0;
         qcol_ff    <= '0;
         qrow_ff    <= '0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         fwidth_ff  <= fwidth_in;
         fheight_ff <= fheight_in;
         pos_ff     <= pos_in;
         qcol_ff    <= qcol_in;
         qrow_ff    <= qrow_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      wid_ff  <= wid_in;
      hgt_ff  <= hgt_in;
      npix_ff <= npix_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
   end

   assign run      = (state_ff == sbl_pkg::ST_RUN);
   assign pix_slot = pos_ff < npix_ff;

   always_comb begin
      item.col       = qcol_ff;
      item.bank      = qrow_ff[sbl_pkg::BANK_W-1:0];
      item.fresh_ok  = (pos_ff > PW'(1)) && (qrow_ff < hgt_ext);
      item.out_ok    = (pos_ff > PW'(1)) && (qrow_ff > RW'(1));
      item.frame_end = (qrow_ff == hgt_ext + RW'(1)) && (qcol_ff == wid_ff - CW'(1));
      item.edge_l2   = qcol_ff < CW'(2);
      item.edge_l1   = qcol_ff == '0;
      item.edge_r1   = qcol_ff == wid_ff - CW'(1);
      item.edge_r2   = qcol_ff >= wid_ff - CW'(2);
      item.top2      = qrow_ff < RW'(4);
      item.top1      = qrow_ff < RW'(3);
      item.bot1      = qrow_ff >= hgt_ext + RW'(1);
      item.bot2      = qrow_ff >= hgt_ext;
   end

endmodule

`default_nettype wire

// File: rtl/core/sbl_lane.sv
// ----------------------------------------------------------------------------
// sbl_lane
// one color channel: pixel window, row sums, line buffers, column sum, scaling
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_lane #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic [7:0]                    new_px,
   input  wire logic [sbl_pkg::COL_W-1:0]     rd_col,
   input  wire logic                          ram_we,
   input  wire logic                          ld2,
   input  wire logic                          ld3,
   input  wire sbl_pkg::sbl_item_type         ctl,
   output logic      [7:0]                    result
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int SW = sbl_pkg::SUM_W;
   localparam int VW = sbl_pkg::VSUM_W;
   localparam int BW = sbl_pkg::BANK_W;

   logic [7:0]    win_ff [5];
   logic [SW-1:0] rd_q [sbl_pkg::LINE_ROWS];
   logic [SW-1:0] fresh;
   logic [7:0]    hp_m2, hp_m1, hp_p1, hp_p2;
   logic [SW-1:0] row_m2, row_m1, row_c, row_p1;
   logic [SW-1:0] t_ff [5];
   logic [VW-1:0] vsum_ff;
   logic [VW-1:0] vsum;

   // round half to even of s/96, saturated
   function automatic logic [7:0] scale_round(input logic [VW-1:0] s);
      logic [9:0]  t;
      logic [19:0] prod;
      logic [8:0]  q0;
      logic [9:0]  r3;
      logic [6:0]  rem;
      logic        up;
      logic [8:0]  qr;
      t    = s[VW-1:5];
      prod = 20'(t) * 20'd683;
      q0   = prod[19:11];
      r3   = t - {q0, 1'b0} - {1'b0, q0};
      rem  = {r3[1:0], s[4:0]};
      up   = (rem > 7'd48) || ((rem == 7'd48) && q0[0]);
      qr   = q0 + 9'(up);
      return (qr > 9'd255) ? 8'd255 : qr[7:0];
   endfunction

   // pixel window, shifted once per pixel transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            win_ff[i] <= '0;
         end
      end else if (take) begin
         for (int i = 0; i < 4; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[4] <= new_px;
      end
   end

   // row sum, edge taps fall back to the centre pixel
   assign hp_m2 = ctl.edge_l2 ? win_ff[2] : win_ff[0];
   assign hp_m1 = ctl.edge_l1 ? win_ff[2] : win_ff[1];
   assign hp_p1 = ctl.edge_r1 ? win_ff[2] : win_ff[3];
   assign hp_p2 = ctl.edge_r2 ? win_ff[2] : win_ff[4];
   assign fresh = SW'(hp_m2) + {3'd0, hp_m1, 1'b0} + {2'd0, win_ff[2], 2'b00}
                + {3'd0, hp_p1, 1'b0} + SW'(hp_p2);

   for (genvar b = 0; b < sbl_pkg::LINE_ROWS; b++) begin : g_bank
      sbl_ram #(
         .WIDTH (SW),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock (clock),
         .we    (ram_we && (ctl.bank == BW'(b))),
         .waddr (AW'(ctl.col)),
         .wdata (fresh),
         .re    (take),
         .raddr (AW'(rd_col)),
         .rdata (rd_q[b])
      );
   end

   assign row_m2 = rd_q[ctl.bank];
   assign row_m1 = rd_q[ctl.bank + BW'(1)];
   assign row_c  = rd_q[ctl.bank + BW'(2)];
   assign row_p1 = rd_q[ctl.bank + BW'(3)];

   always_ff @(posedge clock) begin
      if (ld2) begin
         t_ff[0] <= ctl.top2 ? row_c : row_m2;
         t_ff[1] <= ctl.top1 ? row_c : row_m1;
         t_ff[2] <= row_c;
         t_ff[3] <= ctl.bot1 ? row_c : row_p1;
         t_ff[4] <= ctl.bot2 ? row_c : fresh;
      end
   end

   assign vsum = VW'(t_ff[0]) + {2'd0, t_ff[1], 1'b0} + {1'b0, t_ff[2], 2'b00}
               + {2'd0, t_ff[3], 1'b0} + VW'(t_ff[4]);

   always_ff @(posedge clock) begin
      if (ld3) begin
         vsum_ff <= vsum;
      end
   end

   assign result = scale_round(vsum_ff);

endmodule

`default_nettype wire

// File: rtl/core/separable_blur_5x5_rgb.sv
// ----------------------------------------------------------------------------
// separable_blur_5x5_rgb
// streaming 1-2-4-2-1 separable blur of raster-order bgr pixels
// ----------------------------------------------------------------------------
// path: a pixel's result passes s1, s2, s3 and the out register after the
//   transaction that completes its window, input transaction k + 2*width + 2
// throughput: one transaction per cycle unless the output stalls, set by the
//   three color lanes and one write plus one read port per line-buffer bank
// reset and every csr write: req_ready stays low while the frame geometry is
//   latched and the position is resolved by a serial divider
`default_nettype none

module separable_blur_5x5_rgb #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire sbl_pkg::sbl_req_type           req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output sbl_pkg::sbl_rsp_type                rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [sbl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sbl_pkg::CSR_DATA_W-1:0] csr_data
);

   logic                  run;
   logic                  pix_slot;
   sbl_pkg::sbl_item_type item;
   logic                  accept;
   logic                  take;

   // stage valids: s1 row sums, s2 column taps, s3 column sum, out register
   logic                  v1_ff, v2_ff, v3_ff, vo_ff;
   logic                  ld1, ld2, ld3, ldo;
   sbl_pkg::sbl_item_type ctl1_ff;
   logic                  fe2_ff, fe3_ff;
   sbl_pkg::sbl_rsp_type  rsp_ff;
   logic                  ram_we;
   logic [7:0]            px_b, px_g, px_r;
   logic [7:0]            res_b, res_g, res_r;

   // csr writes are always taken; the tracker holds off input while it resolves
   assign csr_ready = 1'b1;

   sbl_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .take      (take),
      .run       (run),
      .pix_slot  (pix_slot),
      .item      (item)
   );

   // each stage loads when empty or when its successor moves on
   assign ldo = !vo_ff || rsp_ready;
   assign ld3 = !v3_ff || ldo;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;

   assign req_ready = run && ld1;
   assign accept    = req_valid && req_ready;
   // a flush inside the pixel slots is dropped without touching state
   assign take      = accept && !(pix_slot && req_data.flush);

   // drain slots feed zero pixels into the window
   assign px_b = pix_slot ? req_data.blue_in  : 8'd0;
   assign px_g = pix_slot ? req_data.green_in : 8'd0;
   assign px_r = pix_slot ? req_data.red_in   : 8'd0;

   // row sum goes to the line buffer as its item leaves s1
   assign ram_we = v1_ff && ctl1_ff.fresh_ok && ld2;

   sbl_lane #(.MAX_WIDTH (MAX_WIDTH)) u_lane_b (
      .clock (clock), .reset (reset), .take (take), .new_px (px_b),
      .rd_col (item.col), .ram_we (ram_we), .ld2 (ld2), .ld3 (ld3),
      .ctl (ctl1_ff), .result (res_b)
   );

   sbl_lane #(.MAX_WIDTH (MAX_WIDTH)) u_lane_g (
      .clock (clock), .reset (reset), .take (take), .new_px (px_g),
      .rd_col (item.col), .ram_we (ram_we), .ld2 (ld2), .ld3 (ld3),
      .ctl (ctl1_ff), .result (res_g)
   );

   sbl_lane #(.MAX_WIDTH (MAX_WIDTH)) u_lane_r (
      .clock (clock), .reset (reset), .take (take), .new_px (px_r),
      .rd_col (item.col), .ram_we (ram_we), .ld2 (ld2), .ld3 (ld3),
      .ctl (ctl1_ff), .result (res_r)
   );

   // control side of the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (ld1) begin
            v1_ff <= take;
         end
         // items without an output pixel end at s1
         if (ld2) begin
            v2_ff <= v1_ff && ctl1_ff.out_ok;
         end
         if (ld3) begin
            v3_ff <= v2_ff;
         end
         if (ldo) begin
            vo_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld1 && take) begin
         ctl1_ff <= item;
      end
      if (ld2) begin
         fe2_ff <= ctl1_ff.frame_end;
      end
      if (ld3) begin
         fe3_ff <= fe2_ff;
      end
      // merge the three lanes into one response transaction
      if (ldo) begin
         rsp_ff.blue_out  <= res_b;
         rsp_ff.green_out <= res_g;
         rsp_ff.red_out   <= res_r;
         rsp_ff.frame_end <= fe3_ff;
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/sbl_checker.sv
// ----------------------------------------------------------------------------
// sbl_checker
// port-level checks of the separable blur, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire sbl_pkg::sbl_rsp_type           rsp_data,
   input wire logic                           csr_valid,
   input wire logic                           csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

   a_csr_block: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("input taken right after a csr write");

endmodule

bind separable_blur_5x5_rgb sbl_checker u_sbl_checker (.*);

`default_nettype wire

// File: test/tb_separable_blur_5x5_rgb.sv
// ----------------------------------------------------------------------------
// tb_separable_blur_5x5_rgb
// self-checking bench for the streaming 5x5 separable rgb blur
// ----------------------------------------------------------------------------
// whole frames are queued as pixel transactions followed by their drain
// slots. A clocked driver feeds the block from that queue and a clocked
// monitor predicts each accepted transaction and checks the results in
// order. Frame geometry only changes between frames, once the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_separable_blur_5x5_rgb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH = 1024;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 600;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   sbl_pkg::sbl_req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   sbl_pkg::sbl_rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [sbl_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sbl_pkg::CSR_DATA_W-1:0] csr_data;

   separable_blur_5x5_rgb u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // pixels waiting for the driver and blurred pixels waiting for the block
   sbl_pkg::sbl_req_type pixel_queue[$];
   sbl_pkg::sbl_rsp_type blur_queue[$];

   int unsigned error_count = 0;
   int idle_mode = 0;      // 0 none, 1 sender, 2 receiver, 3 both
   int hold_asked = 0;
   int hold_done = 0;
   int hold_left = 0;
   int stall_cycles = 0;
   logic req_taken;
   logic csr_taken;

   // predictor state, mirrors the block
   logic [35:0] row_sums[0:sbl_pkg::LINE_ROWS*LINE_DEPTH-1];
   logic [23:0] window_px[0:4];
   int unsigned frame_pos;
   logic [10:0] cfg_width;
   logic [15:0] cfg_height;

   task automatic report(input string what, input int got, input int want);
      $display("error: %s got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic int eff_width(input logic [10:0] w);
      if (w < 5) return 5;
      if (w > LINE_DEPTH) return LINE_DEPTH;
      return w;
   endfunction

   function automatic int eff_height(input logic [15:0] h);
      return (h == 0) ? 1 : h;
   endfunction

   // divide by 96, round half to even, saturate
   function automatic logic [7:0] scale_sum(input int s);
      int q;
      int r;
      q = s / 96;
      r = s % 96;
      if (r > 48 || (r == 48 && q[0])) q++;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   // advance the blur model by one accepted transaction
   function automatic void blur_step(input sbl_pkg::sbl_req_type px);
      int w;
      int h;
      int npix;
      int total;
      int p;
      int q;
      int k;
      int r;
      int c;
      int rr;
      int s;
      int tap[5];
      logic [35:0] fresh;
      logic [35:0] centre;
      logic [35:0] src;
      logic [23:0] pv;
      logic [7:0] chan[3];
      bit fresh_ok;
      sbl_pkg::sbl_rsp_type want;
      tap = '{1, 2, 4, 2, 1};
      w = eff_width(cfg_width);
      h = eff_height(cfg_height);
      npix = w * h;
      total = npix + 2 * w + 2;
      fresh_ok = 0;
      fresh = '0;
      if (frame_pos >= total) frame_pos = 0;
      p = frame_pos;
      // flush inside the pixel slots is ignored
      if (p < npix && px.flush) return;
      for (int i = 0; i < 4; i++) window_px[i] = window_px[i+1];
      window_px[4] = (p < npix) ? {px.red_in, px.green_in, px.blue_in} : 24'd0;
      if (p >= 2 && p - 2 < npix) begin
         q = p - 2;
         c = q % w;
         for (int ch = 0; ch < 3; ch++) begin
            s = 0;
            for (int m = -2; m <= 2; m++) begin
               pv = (c + m < 0 || c + m >= w) ? window_px[2] : window_px[2+m];
               s += tap[m+2] * pv[8*ch +: 8];
            end
            fresh[12*ch +: 12] = s[11:0];
         end
         fresh_ok = 1;
      end
      if (p >= 2 * w + 2 && p - (2 * w + 2) < npix) begin
         k = p - (2 * w + 2);
         r = k / w;
         c = k % w;
         centre = row_sums[(r % sbl_pkg::LINE_ROWS) * LINE_DEPTH + c];
         for (int ch = 0; ch < 3; ch++) begin
            s = 0;
            for (int m = -2; m <= 2; m++) begin
               rr = r + m;
               if (rr < 0 || rr >= h) src = centre;
               else if (m == 2) src = fresh;
               else src = row_sums[(rr % sbl_pkg::LINE_ROWS) * LINE_DEPTH + c];
               s += tap[m+2] * src[12*ch +: 12];
            end
            chan[ch] = scale_sum(s);
         end
         want.blue_out = chan[0];
         want.green_out = chan[1];
         want.red_out = chan[2];
         want.frame_end = (k == npix - 1);
         blur_queue.push_back(want);
      end
      if (fresh_ok)
         row_sums[((p - 2) / w % sbl_pkg::LINE_ROWS) * LINE_DEPTH + (p - 2) % w] = fresh;
      frame_pos = p + 1;
      if (frame_pos >= total) frame_pos = 0;
   endfunction

   // driver: inputs move on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pixel_queue.size() > 0 &&
             !((idle_mode == 1 && $urandom_range(99) < 67) ||
               (idle_mode == 3 && $urandom_range(99) < 21))) begin
            req_data <= pixel_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_asked != hold_done) begin
         hold_done = hold_asked;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !((idle_mode == 2 && $urandom_range(99) < 67) ||
                        (idle_mode == 3 && $urandom_range(99) < 21));
      end
   end

   // monitor: sample on the rising edge, predict, check, watch for a hang
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      csr_taken <= csr_valid && csr_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == sbl_pkg::CSR_FRAME_WIDTH) cfg_width = csr_data[10:0];
            else if (csr_index == sbl_pkg::CSR_FRAME_HEIGHT) cfg_height = csr_data;
         end
         if (req_valid && req_ready) blur_step(req_data);
         if (rsp_valid && rsp_ready) begin
            if (blur_queue.size() == 0) begin
               report("unexpected transaction, frame_end", rsp_data.frame_end, 0);
            end else begin
               sbl_pkg::sbl_rsp_type want;
               want = blur_queue.pop_front();
               if (rsp_data.blue_out != want.blue_out)
                  report("blue_out", rsp_data.blue_out, want.blue_out);
               if (rsp_data.green_out != want.green_out)
                  report("green_out", rsp_data.green_out, want.green_out);
               if (rsp_data.red_out != want.red_out)
                  report("red_out", rsp_data.red_out, want.red_out);
               if (rsp_data.frame_end != want.frame_end)
                  report("frame_end", rsp_data.frame_end, want.frame_end);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else if (++stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // one register write, held until the block takes it
   task automatic csr_write(input logic [sbl_pkg::CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[15:0];
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pixel_queue.size() != 0 || req_valid || blur_queue.size() != 0)
         @(posedge clock);
      // trailing ignored flushes may still be in flight
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         default: return $urandom_range(255);
      endcase
   endfunction

   function automatic sbl_pkg::sbl_req_type rand_pixel(input bit flush);
      sbl_pkg::sbl_req_type it;
      it.blue_in = rand_chan();
      it.green_in = rand_chan();
      it.red_in = rand_chan();
      it.flush = flush;
      return it;
   endfunction

   // queue one full frame with drain; noise adds ignored flushes and
   // pixels in drain slots
   task automatic queue_frame(input int w, input int h, input bit noise);
      for (int i = 0; i < w * h; i++) begin
         if (noise && $urandom_range(9) == 0) pixel_queue.push_back(rand_pixel(1));
         pixel_queue.push_back(rand_pixel(0));
      end
      for (int i = 0; i < 2 * w + 2; i++)
         pixel_queue.push_back(rand_pixel(!(noise && $urandom_range(6) == 0)));
   endtask

   initial begin
      sbl_pkg::sbl_req_type it;
      int w;
      int h;
      int wr;
      int hr;
      int budget;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = sbl_pkg::CSR_FRAME_WIDTH;
      csr_data = '0;
      req_taken = 1'b0;
      csr_taken = 1'b0;
      frame_pos = 0;
      cfg_width = sbl_pkg::RESET_WIDTH;
      cfg_height = sbl_pkg::RESET_HEIGHT;
      foreach (window_px[i]) window_px[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: narrowest single-row frame of extremes, an ignored flush,
      // a pixel in a drain slot; widths and height below range clamp
      csr_write(sbl_pkg::CSR_FRAME_WIDTH, 0);
      csr_write(sbl_pkg::CSR_FRAME_HEIGHT, 0);
      for (int i = 0; i < 5; i++) begin
         it = '0;
         if (i[0]) begin
            it.blue_in = 8'hff;
            it.green_in = 8'hff;
            it.red_in = 8'hff;
         end
         pixel_queue.push_back(it);
         if (i == 2) begin
            it.flush = 1'b1;
            pixel_queue.push_back(it);
         end
      end
      for (int i = 0; i < 12; i++) pixel_queue.push_back(rand_pixel(i != 3));
      wait_idle();
      // all-white frame saturates every channel
      csr_write(sbl_pkg::CSR_FRAME_WIDTH, 4);
      for (int i = 0; i < 17; i++) begin
         it = '1;
         it.flush = (i >= 5);
         pixel_queue.push_back(it);
      end
      wait_idle();

      // random phases across the idling modes, small geometries
      for (int mode = 0; mode < 4; mode++) begin
         idle_mode = mode;
         for (int sub = 0; sub < 2; sub++) begin
            wr = ($urandom_range(4) == 0) ? $urandom_range(4) : $urandom_range(5, 12);
            hr = $urandom_range(6);
            w = eff_width(wr);
            h = eff_height(hr);
            csr_write(sbl_pkg::CSR_FRAME_WIDTH, wr);
            csr_write(sbl_pkg::CSR_FRAME_HEIGHT, hr);
            budget = 0;
            while (budget < 160) begin
               queue_frame(w, h, 1);
               budget += w * h + 2 * w + 2;
            end
            // long receiver hold-off while the sender keeps offering
            if (mode == 0 && sub == 0) hold_asked++;
            wait_idle();
         end
      end

      // largest settings written then replaced, then a wider two-row frame
      idle_mode = 3;
      csr_write(sbl_pkg::CSR_FRAME_HEIGHT, 65535);
      csr_write(sbl_pkg::CSR_FRAME_WIDTH, 2047);
      csr_write(sbl_pkg::CSR_FRAME_WIDTH, 40);
      csr_write(sbl_pkg::CSR_FRAME_HEIGHT, 2);
      queue_frame(40, 2, 1);
      wait_idle();

      if (error_count == 0 && blur_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
rtl/core/sbl_pkg.sv
rtl/core/sbl_ram.sv
rtl/core/sbl_ctrl.sv
rtl/core/sbl_lane.sv
rtl/core/separable_blur_5x5_rgb.sv
rtl/core/sbl_checker.sv
test/tb_separable_blur_5x5_rgb.sv
